// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset low disables.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, reset low disables.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== src/pip_pkg.sv =====
// Shared types and constants of the point-in-polygon block.
package pip_pkg;

  // decoupling queue between edge classifier and parity back end
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_X = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_Y = 1'b1;

  // structure flags of one vertex, implied ends already folded in
  typedef struct packed {
    logic first;
    logic end_ring;
    logic end_poly;
    logic end_geom;
  } pip_flags_t;

  // classified vertex handed from front to back
  typedef struct packed {
    pip_flags_t flags;
    logic       tog_in;
    logic       tog_close;
  } pip_rec_t;

endpackage

// ===== src/point_in_polygon_with_holes.sv =====
// Even-odd ray-casting point-in-polygon test, top level.
//
// Streams the vertices of a polygon or multipolygon with holes, one vertex per
// request, and tests the query point (query_x, query_y, written through the
// config port while idle) against it. Each ring's parity toggles for every
// edge, including the closing edge back to the ring's first vertex, that
// straddles the horizontal through the query point with its crossing strictly
// right of query_x. The crossing test is exact: (qx - x1) * dy is compared
// with (x2 - x1) * (qy - y1), the compare flipped when dy is negative, on
// full-width signed products, so no rounding at any coordinate. A polygon
// holds the point if its outer ring does and none of its holes does; one
// result (inside_res_o) comes per geometry, on the vertex marked
// last_in_geometry. Missing ring starts chain from the stored previous vertex
// (0,0 after reset). Implied ends: geometry end implies polygon end, which
// implies ring end.
//
// Rate: one vertex per clock while in_stall_o is low. The front end runs both
// edges of a vertex through a two-stage difference/multiply pipeline (four
// (W+1)x(W+1) multipliers) and pushes a classified record into an 8-entry
// queue; the back end retires one record per clock unless a geometry end waits
// on a stalled result. A result passes both stages, the queue and the result
// register. in_stall_o rises once 8 vertices sit between input and back end.
// Config writes are always taken (cfg_ready_o is tied high).
module point_in_polygon_with_holes import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  // vertex requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic                          first_in_ring_i,
  input  logic                          last_in_ring_i,
  input  logic                          last_in_polygon_i,
  input  logic                          last_in_geometry_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o
);

  logic     push, pop, empty;
  pip_rec_t rec_push, rec_pop;

  assign cfg_ready_o = 1'b1;

  // edge classifier: ring bookkeeping and crossing test
  pip_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .vertex_x_i,
    .vertex_y_i,
    .first_in_ring_i,
    .last_in_ring_i,
    .last_in_polygon_i,
    .last_in_geometry_i,
    .pop_i             (pop),
    .push_o            (push),
    .rec_o             (rec_push)
  );

  // decoupling queue, never overfilled thanks to front-end credits
  pip_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (rec_push),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rec_pop)
  );

  // parity and polygon/hole combining, result register
  pip_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i      (empty),
    .rec_i        (rec_pop),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .inside_res_o
  );

endmodule

// ===== src/pip_front.sv =====
// Front end: accepts vertices, forms edges and runs the exact crossing test.
module pip_front import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic                          first_in_ring_i,
  input  logic                          last_in_ring_i,
  input  logic                          last_in_polygon_i,
  input  logic                          last_in_geometry_i,
  input  logic                          pop_i,
  output logic                          push_o,
  output pip_rec_t                      rec_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned LANES = 2;   // lane 0: incoming edge, lane 1: closing edge

  logic signed [W-1:0] query_x_q, query_y_q;
  logic signed [W-1:0] prev_x_q, prev_y_q, ring_x_q, ring_y_q;
  logic [QUEUE_CW-1:0] credit_q, credit_d;
  logic                acc;
  pip_flags_t          flags;
  logic signed [W-1:0] first_x, first_y;

  logic signed [W-1:0] e_x1 [LANES];
  logic signed [W-1:0] e_y1 [LANES];
  logic signed [W-1:0] e_x2 [LANES];
  logic signed [W-1:0] e_y2 [LANES];
  logic [LANES-1:0]    lane_en, strad_d;

  // stage 1: differences
  logic              v1_q;
  pip_flags_t        flags1_q;
  logic signed [W:0] dy_q [LANES];
  logic signed [W:0] px_q [LANES];
  logic signed [W:0] dx_q [LANES];
  logic signed [W:0] py_q [LANES];
  logic [LANES-1:0]  strad1_q;

  // stage 2: products
  logic               v2_q;
  pip_flags_t         flags2_q;
  logic signed [PW-1:0] lp_q [LANES];
  logic signed [PW-1:0] rp_q [LANES];
  logic [LANES-1:0]   strad2_q, neg2_q, tog;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (credit_q == QUEUE_CW'(QUEUE_DEPTH));

  always_comb begin
    flags.end_geom = last_in_geometry_i;
    flags.end_poly = last_in_polygon_i || last_in_geometry_i;
    flags.end_ring = last_in_ring_i || flags.end_poly;
    flags.first    = first_in_ring_i;
  end

  // ring start latches this vertex as the first one
  assign first_x = first_in_ring_i ? vertex_x_i : ring_x_q;
  assign first_y = first_in_ring_i ? vertex_y_i : ring_y_q;

  assign e_x1[0] = vertex_x_i;
  assign e_y1[0] = vertex_y_i;
  assign e_x2[0] = prev_x_q;
  assign e_y2[0] = prev_y_q;
  assign e_x1[1] = first_x;
  assign e_y1[1] = first_y;
  assign e_x2[1] = vertex_x_i;
  assign e_y2[1] = vertex_y_i;

  assign lane_en[0] = !first_in_ring_i;
  assign lane_en[1] = flags.end_ring;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign strad_d[l] = lane_en[l] && ((query_y_q < e_y1[l]) != (query_y_q < e_y2[l]));

    always_ff @(posedge clk_i) begin
      dy_q[l]     <= {e_y2[l][W-1], e_y2[l]} - {e_y1[l][W-1], e_y1[l]};
      px_q[l]     <= {query_x_q[W-1], query_x_q} - {e_x1[l][W-1], e_x1[l]};
      dx_q[l]     <= {e_x2[l][W-1], e_x2[l]} - {e_x1[l][W-1], e_x1[l]};
      py_q[l]     <= {query_y_q[W-1], query_y_q} - {e_y1[l][W-1], e_y1[l]};
      strad1_q[l] <= strad_d[l];
    end

    // L = (qx - x1) * dy, R = (x2 - x1) * (qy - y1)
    always_ff @(posedge clk_i) begin
      lp_q[l]     <= {{(W+1){px_q[l][W]}}, px_q[l]} * {{(W+1){dy_q[l][W]}}, dy_q[l]};
      rp_q[l]     <= {{(W+1){dx_q[l][W]}}, dx_q[l]} * {{(W+1){py_q[l][W]}}, py_q[l]};
      strad2_q[l] <= strad1_q[l];
      neg2_q[l]   <= dy_q[l][W];
    end

    // rising edge: L < R, falling edge: R < L
    assign tog[l] = strad2_q[l] && (neg2_q[l] ? (rp_q[l] < lp_q[l]) : (lp_q[l] < rp_q[l]));
  end

  always_ff @(posedge clk_i) begin
    flags1_q <= flags;
    flags2_q <= flags1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= acc;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_QUERY_X) begin
        query_x_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_QUERY_Y) begin
        query_y_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      ring_x_q <= '0;
      ring_y_q <= '0;
    end else if (acc) begin
      prev_x_q <= vertex_x_i;
      prev_y_q <= vertex_y_i;
      ring_x_q <= first_x;
      ring_y_q <= first_y;
    end
  end

  // credits cover the pipeline plus queue so a push always finds room
  always_comb begin
    case ({acc, pop_i})
      2'b10:   credit_d = credit_q + QUEUE_CW'(1);
      2'b01:   credit_d = credit_q - QUEUE_CW'(1);
      default: credit_d = credit_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  assign push_o          = v2_q;
  assign rec_o.flags     = flags2_q;
  assign rec_o.tog_in    = tog[0];
  assign rec_o.tog_close = tog[1];

endmodule

// ===== src/pip_queue.sv =====
// Small FIFO of classified vertices between front and back.
module pip_queue import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pip_rec_t wdata_i,
  input  logic     pop_i,
  output logic     empty_o,
  output pip_rec_t rdata_o
);

  pip_rec_t            slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QUEUE_CW'(1);
        2'b01:   count_q <= count_q - QUEUE_CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign empty_o = (count_q == '0);
  assign rdata_o = slot_q[rd_ptr_q];

endmodule

// ===== src/pip_back.sv =====
// Back end: ring parity, hole and polygon combining, result register.
module pip_back import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  pip_rec_t rec_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output logic     inside_res_o
);

  logic parity_q, parity_d;
  logic outer_q, outer_d;
  logic holds_q, holds_d;
  logic hit_q, hit_d;
  logic out_valid_q, out_valid_d;
  logic inside_q, inside_d;

  // only a geometry end needs the result register free
  assign pop_o = !empty_i && (!rec_i.flags.end_geom || !out_valid_q || !out_stall_i);

  always_comb begin
    parity_d    = parity_q;
    outer_d     = outer_q;
    holds_d     = holds_q;
    hit_d       = hit_q;
    inside_d    = inside_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      if (rec_i.flags.first) begin
        parity_d = 1'b0;
      end
      if (rec_i.tog_in) begin
        parity_d = !parity_d;
      end
      if (rec_i.flags.end_ring) begin
        if (rec_i.tog_close) begin
          parity_d = !parity_d;
        end
        if (outer_d) begin
          holds_d = parity_d;
        end else if (parity_d) begin
          holds_d = 1'b0;   // point sits in a hole
        end
        outer_d  = 1'b0;
        parity_d = 1'b0;
      end
      if (rec_i.flags.end_poly) begin
        hit_d   = hit_d || holds_d;
        holds_d = 1'b0;
        outer_d = 1'b1;
      end
      if (rec_i.flags.end_geom) begin
        inside_d    = hit_d;
        out_valid_d = 1'b1;
        hit_d       = 1'b0;
        holds_d     = 1'b0;
        parity_d    = 1'b0;
        outer_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q    <= 1'b0;
      outer_q     <= 1'b1;
      holds_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      parity_q    <= parity_d;
      outer_q     <= outer_d;
      holds_q     <= holds_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule

// ===== src/pip_checker.sv =====
// Port-level checks of the point-in-polygon block, bound to the top level.
`include "assert_macros.svh"

module pip_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic last_in_geometry_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic inside_res_o
);

  // geometries taken whose result has not been delivered yet
  logic [4:0] pend_q;
  logic       geom_acc, out_acc;

  assign geom_acc = in_valid_i && !in_stall_o && last_in_geometry_i;
  assign out_acc  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      case ({geom_acc, out_acc})
        2'b10:   pend_q <= pend_q + 5'd1;
        2'b01:   pend_q <= pend_q - 5'd1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  `CHK_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `CHK_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(inside_res_o))
  `CHK_SAME(a_no_extra_result, clk_i, rst_ni, out_valid_o, pend_q != 5'd0)
  `CHK_SAME(a_stall_after_take, clk_i, rst_ni, $rose(in_stall_o), $past(in_valid_i && !in_stall_o))

endmodule

bind point_in_polygon_with_holes pip_checker u_pip_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .last_in_geometry_i (last_in_geometry_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .inside_res_o       (inside_res_o)
);

// ===== tb/tb_point_in_polygon_with_holes.sv =====
// Self-checking testbench of the even-odd point-in-polygon block.
module tb_point_in_polygon_with_holes;
  import pip_pkg::*;

  localparam int unsigned W = 32;
  // the queue and pipeline may still hold vertices that cause no result,
  // so let this many clocks pass when idle
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES  = 500_000;
  localparam int unsigned RANDOM_ITEMS  = 1250;

  typedef logic signed [W-1:0]     coord_t;
  // 33-bit differences multiply into 66 bits; keep some headroom
  typedef logic signed [2*W+3:0]   wide_t;

  localparam coord_t COORD_MIN = {1'b1, {(W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(W-1){1'b1}}};

  // clock, reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  // block inputs, known from time zero
  logic                   cfg_valid_i        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i        = CFG_QUERY_X;
  logic [W-1:0]           cfg_data_i         = '0;
  logic                   in_valid_i         = 1'b0;
  coord_t                 vertex_x_i         = '0;
  coord_t                 vertex_y_i         = '0;
  logic                   first_in_ring_i    = 1'b0;
  logic                   last_in_ring_i     = 1'b0;
  logic                   last_in_polygon_i  = 1'b0;
  logic                   last_in_geometry_i = 1'b0;
  logic                   out_stall_i        = 1'b0;

  // block outputs
  logic cfg_ready_o;
  logic in_stall_o;
  logic out_valid_o;
  logic inside_res_o;

  point_in_polygon_with_holes #(
    .COORD_WIDTH(W)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .vertex_x_i        (vertex_x_i),
    .vertex_y_i        (vertex_y_i),
    .first_in_ring_i   (first_in_ring_i),
    .last_in_ring_i    (last_in_ring_i),
    .last_in_polygon_i (last_in_polygon_i),
    .last_in_geometry_i(last_in_geometry_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .inside_res_o      (inside_res_o)
  );

  // ---------------------------------------------------------------------
  // Predictor state: mirrors the block's query registers and ring tracking
  // ---------------------------------------------------------------------
  coord_t query_x_q   = '0;
  coord_t query_y_q   = '0;
  coord_t ring_x0     = '0;  // first vertex of current ring
  coord_t ring_y0     = '0;
  coord_t prev_x      = '0;  // last vertex taken
  coord_t prev_y      = '0;
  bit     ring_odd    = 1'b0;
  bit     ring_outer  = 1'b1;  // next ring to close is an outer ring
  bit     poly_holds  = 1'b0;
  bit     geom_hit    = 1'b0;

  bit pending_inside[$];  // predicted inside_res, oldest first
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;

  // sides' idling controls, owned by the test sequence
  bit          in_idle_on  = 1'b0;
  bit          out_idle_on = 1'b0;
  int unsigned hold_request = 0;  // long receiver hold-off, in cycles

  // Does edge (x1,y1)-(x2,y2) straddle the query row with its crossing
  // strictly right of query x? Exact cross-multiplied compare, no division.
  function automatic bit crosses_right_of_query(coord_t x1, coord_t y1,
                                                coord_t x2, coord_t y2);
    wide_t dy;
    wide_t lhs;
    wide_t rhs;
    if ((query_y_q < y1) == (query_y_q < y2))
      return 1'b0;
    dy  = wide_t'(y2) - wide_t'(y1);
    lhs = (wide_t'(query_x_q) - wide_t'(x1)) * dy;
    rhs = (wide_t'(x2) - wide_t'(x1)) * (wide_t'(query_y_q) - wide_t'(y1));
    // dy > 0: crossing right when lhs < rhs; dy < 0 flips the compare
    return (dy > 0) ? (lhs < rhs) : (rhs < lhs);
  endfunction

  // Config writes, accepted requests and results are all seen at the edge,
  // on the values that stood before it.
  always @(posedge clk_i) begin : track_and_check
    bit end_geom;
    bit end_poly;
    bit end_ring;
    bit want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_QUERY_X: query_x_q = coord_t'(cfg_data_i);
          CFG_QUERY_Y: query_y_q = coord_t'(cfg_data_i);
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_o) begin
        end_geom = last_in_geometry_i;
        end_poly = last_in_polygon_i || end_geom;
        end_ring = last_in_ring_i || end_poly;

        if (first_in_ring_i) begin
          ring_odd = 1'b0;
          ring_x0  = vertex_x_i;
          ring_y0  = vertex_y_i;
        end else if (crosses_right_of_query(vertex_x_i, vertex_y_i, prev_x, prev_y)) begin
          ring_odd = ~ring_odd;
        end
        prev_x = vertex_x_i;
        prev_y = vertex_y_i;

        if (end_ring) begin
          // closing edge back to the ring's first vertex
          if (crosses_right_of_query(ring_x0, ring_y0, vertex_x_i, vertex_y_i))
            ring_odd = ~ring_odd;
          if (ring_outer)
            poly_holds = ring_odd;
          else if (ring_odd)
            poly_holds = 1'b0;  // point sits in a hole
          ring_outer = 1'b0;
          ring_odd   = 1'b0;
        end
        if (end_poly) begin
          geom_hit   = geom_hit || poly_holds;
          poly_holds = 1'b0;
          ring_outer = 1'b1;
        end
        if (end_geom) begin
          pending_inside = {pending_inside, geom_hit};
          geom_hit   = 1'b0;
          poly_holds = 1'b0;
          ring_odd   = 1'b0;
          ring_outer = 1'b1;
        end
      end

      if (out_valid_o && !out_stall_i) begin
        if (pending_inside.size() == 0) begin
          $display("%0t: unexpected result, inside_res expected none actual %0b",
                   $time, inside_res_o);
          error_count++;
        end else begin
          want = pending_inside.pop_front();
          if (inside_res_o !== want) begin
            $display("%0t: inside_res mismatch, expected %0b actual %0b",
                     $time, want, inside_res_o);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(posedge clk_i) begin : result_stall
    int unsigned burst_left;
    int unsigned hold_left;
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (burst_left != 0) begin
      out_stall_i <= 1'b1;
      burst_left--;
    end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      burst_left  = $urandom_range(1, 8) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // One vertex request; returns right after the edge that takes it.
  // Valid is left high so back-to-back requests keep it up.
  task automatic send_vertex(coord_t x, coord_t y, bit first, bit end_ring,
                             bit end_poly, bit end_geom);
    bit stalled;
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    vertex_x_i         <= x;
    vertex_y_i         <= y;
    first_in_ring_i    <= first;
    last_in_ring_i     <= end_ring;
    last_in_polygon_i  <= end_poly;
    last_in_geometry_i <= end_geom;
    // stall is settled mid-cycle; that value holds at the next edge
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    items_sent++;
  endtask

  // Drop valid, wait out every expected result, then let the pipeline and
  // queue empty of vertices that cause none.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_inside.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both query registers; block must be idle.
  task automatic set_query(coord_t qx, coord_t qy);
    bit ready;
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == 0) ? CFG_QUERY_X : CFG_QUERY_Y;
      cfg_data_i  <= (i == 0) ? qx : qy;
      forever begin
        @(negedge clk_i);
        ready = cfg_ready_o;
        @(posedge clk_i);
        if (ready) break;
      end
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly near the query so rings actually surround it; some full range
  // and some extremes.
  function automatic coord_t pick_coord(coord_t center);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6)
      return center + coord_t'(int'($urandom_range(0, 64)) - 32);
    if (sel < 8)
      return coord_t'($urandom);
    case ($urandom_range(0, 3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return center;
    endcase
  endfunction

  // One well-formed geometry: 1-3 polygons, each an outer ring and 0-2
  // holes. Implied lower end flags are sometimes left off.
  task automatic send_geometry();
    int unsigned n_poly;
    int unsigned n_ring;
    int unsigned n_vert;
    bit last_v, last_r, last_p;
    n_poly = $urandom_range(1, 3);
    for (int p = 0; p < n_poly; p++) begin
      n_ring = $urandom_range(1, 3);
      last_p = (p == n_poly - 1);
      for (int r = 0; r < n_ring; r++) begin
        n_vert = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
        last_r = (r == n_ring - 1);
        for (int v = 0; v < n_vert; v++) begin
          last_v = (v == n_vert - 1);
          send_vertex(pick_coord(query_x_q), pick_coord(query_y_q), v == 0,
                      last_v && (!last_r || $urandom_range(0, 1)),
                      last_v && last_r && (!last_p || $urandom_range(0, 1)),
                      last_v && last_r && last_p);
        end
      end
    end
  endtask

  // A short run of arbitrary flags: missing ring starts, stray ends and so on.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send_vertex(pick_coord(query_x_q), pick_coord(query_y_q),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Straight out of reset: vertices without a ring start chain from (0,0).
  task automatic test_ring_start_after_reset();
    send_vertex(coord_t'(5), coord_t'(-5), 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(5), coord_t'(5),  1'b0, 1'b0, 1'b0, 1'b1);
    settle();
  endtask

  // Hand-built shapes around the origin.
  task automatic test_basic_shapes();
    set_query('0, '0);
    // full-range square, corners at the coordinate extremes
    send_vertex(COORD_MIN, COORD_MIN, 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b0, 1'b0, 1'b0, 1'b1);
    // square with a hole over the point; geometry end implies the rest
    send_vertex(coord_t'(-10), coord_t'(-10), 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(10),  coord_t'(-10), 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(10),  coord_t'(10),  1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(-10), coord_t'(10),  1'b0, 1'b1, 1'b0, 1'b0);
    send_vertex(coord_t'(-5),  coord_t'(-5),  1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(5),   coord_t'(-5),  1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(5),   coord_t'(5),   1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(-5),  coord_t'(5),   1'b0, 1'b0, 1'b0, 1'b1);
    // single-vertex ring: degenerate closing edge
    send_vertex(coord_t'(3), coord_t'(0), 1'b1, 1'b1, 1'b1, 1'b1);
    // triangle whose base lies on the query row
    send_vertex(coord_t'(-8), coord_t'(0), 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(8),  coord_t'(0), 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(0),  coord_t'(8), 1'b0, 1'b0, 1'b0, 1'b1);
    // multipolygon: first polygon misses, second holds the point
    send_vertex(coord_t'(20), coord_t'(20), 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(30), coord_t'(20), 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(25), coord_t'(30), 1'b0, 1'b1, 1'b1, 1'b0);
    send_vertex(coord_t'(-4), coord_t'(-4), 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(4),  coord_t'(-4), 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(coord_t'(0),  coord_t'(6),  1'b0, 1'b0, 1'b0, 1'b1);
    settle();
  endtask

  // Receiver holds off while single-vertex geometries keep coming, so the
  // queue fills and the block stalls its input.
  task automatic test_backpressure();
    set_query(coord_t'($urandom), coord_t'($urandom));
    hold_request = 60;
    for (int i = 0; i < 24; i++)
      send_vertex(pick_coord(query_x_q), pick_coord(query_y_q), 1'b1, 1'b1, 1'b1, 1'b1);
    settle();
  endtask

  // Random geometries under several query settings, extremes among them.
  // The last phase runs without idling on either side.
  task automatic test_random_geometries();
    int unsigned phase_end;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_query('0, '0);
        1: set_query(COORD_MIN, COORD_MAX);
        2: set_query(COORD_MAX, COORD_MIN);
        default: set_query(coord_t'($urandom), coord_t'($urandom));
      endcase
      in_idle_on  = (phase != 4);
      out_idle_on = (phase != 4);
      phase_end = items_sent + RANDOM_ITEMS / 5;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0)
          send_noise();
        else
          send_geometry();
      end
      settle();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ring_start_after_reset();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    test_basic_shapes();
    test_backpressure();
    test_random_geometries();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(LIMIT_CYCLES * 12);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/pip_pkg.sv
src/pip_front.sv
src/pip_queue.sv
src/pip_back.sv
src/point_in_polygon_with_holes.sv
src/pip_checker.sv
tb/tb_point_in_polygon_with_holes.sv
